// ----- rtl/selective_repeat_arq_engine_top_assert.svh -----
// Assertion macros for the RTL file that checks its own logic (srarq_seq.sv).
// SRARQ_ASSERT checks an expression at every clock edge outside reset.
// SRARQ_NEXT checks that the consequent holds in the cycle after the antecedent.
`ifndef SELECTIVE_REPEAT_ARQ_ENGINE_TOP_ASSERT_SVH
`define SELECTIVE_REPEAT_ARQ_ENGINE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SRARQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("srarq assertion failed");
`define SRARQ_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srarq assertion failed");
`else
`define SRARQ_ASSERT(lbl, prop)
`define SRARQ_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/srarq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package srarq_pkg;

  // Link geometry
  localparam int SEQ_W   = 3;
  localparam int SEQ_MAX = 7;
  localparam int WINDOW  = 4;
  localparam int WIN_W   = $clog2(WINDOW);
  localparam int PAY_W   = 16;

  // Event codes
  localparam logic [2:0] OP_START   = 3'd0;
  localparam logic [2:0] OP_SEND    = 3'd1;
  localparam logic [2:0] OP_DATA_RX = 3'd2;
  localparam logic [2:0] OP_NAK_RX  = 3'd3;
  localparam logic [2:0] OP_ACK_RX  = 3'd4;
  localparam logic [2:0] OP_FRM_TMO = 3'd5;
  localparam logic [2:0] OP_ACK_TMO = 3'd6;

  // Result kinds
  localparam logic [2:0] KIND_TX      = 3'd0;
  localparam logic [2:0] KIND_DELIVER = 3'd1;
  localparam logic [2:0] KIND_RELEASE = 3'd2;
  localparam logic [2:0] KIND_NOTHING = 3'd3;
  localparam logic [2:0] KIND_REFUSED = 3'd4;

  // Transmitted frame types
  localparam logic [1:0] FT_DATA = 2'd0;
  localparam logic [1:0] FT_NAK  = 2'd1;
  localparam logic [1:0] FT_ACK  = 2'd2;

  // Ack timer actions
  localparam logic [1:0] AT_NONE    = 2'd0;
  localparam logic [1:0] AT_RESTART = 2'd1;
  localparam logic [1:0] AT_STOP    = 2'd2;

  typedef struct packed {
    logic [2:0]       kind;
    logic [1:0]       frame_type;
    logic [SEQ_W-1:0] seq_out;
    logic [SEQ_W-1:0] ack_out;
    logic [PAY_W-1:0] payload_out;
    logic [1:0]       ack_timer;
    logic [2:0]       buffered;
    logic             last;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } push_t;

  // Build one result; last is filled in when the event completes
  function automatic res_t mk_res(input logic [2:0] kind, input logic [1:0] ft,
                                  input logic [SEQ_W-1:0] s, input logic [SEQ_W-1:0] a,
                                  input logic [PAY_W-1:0] p, input logic [1:0] at,
                                  input logic [2:0] b);
    res_t r;
    r.kind        = kind;
    r.frame_type  = ft;
    r.seq_out     = s;
    r.ack_out     = a;
    r.payload_out = p;
    r.ack_timer   = at;
    r.buffered    = b;
    r.last        = 1'b0;
    return r;
  endfunction

  // Sequence successor, wraps past SEQ_MAX
  function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] a);
    return (a == SEQ_W'(SEQ_MAX)) ? '0 : a + SEQ_W'(1);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/srarq_cmp.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Shared circular window test: true when b lies in [a, c) modulo the sequence space.
module srarq_cmp (
  input  wire logic [srarq_pkg::SEQ_W-1:0] a,
  input  wire logic [srarq_pkg::SEQ_W-1:0] b,
  input  wire logic [srarq_pkg::SEQ_W-1:0] c,
  output logic                             hit
);

  logic a_le_b;
  logic b_lt_c;
  logic c_lt_a;

  assign a_le_b = (a <= b);
  assign b_lt_c = (b < c);
  assign c_lt_a = (c < a);

  assign hit = (a_le_b && b_lt_c) || (c_lt_a && a_le_b) || (b_lt_c && c_lt_a);

endmodule

`default_nettype wire

// ----- rtl/srarq_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "selective_repeat_arq_engine_top_assert.svh"

// Event sequencer: holds both windows and the stores, and walks one event
// through its steps, producing at most one result per cycle.
module srarq_seq (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [2:0]                       op,
  input  wire logic [srarq_pkg::SEQ_W-1:0]      seq_num,
  input  wire logic [srarq_pkg::SEQ_W-1:0]      ack_num,
  input  wire logic [srarq_pkg::PAY_W-1:0]      payload,
  input  wire logic                             emit_ready,
  output srarq_pkg::push_t                      push
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_START  = 4'd1;
  localparam logic [3:0] S_SEND   = 4'd2;
  localparam logic [3:0] S_RX_NAK = 4'd3;
  localparam logic [3:0] S_RX_CHK = 4'd4;
  localparam logic [3:0] S_RX_DLV = 4'd5;
  localparam logic [3:0] S_NAK    = 4'd6;
  localparam logic [3:0] S_TMO    = 4'd7;
  localparam logic [3:0] S_ACKT   = 4'd8;
  localparam logic [3:0] S_REL    = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  localparam int SW = srarq_pkg::SEQ_W;
  localparam int WW = srarq_pkg::WIN_W;
  localparam int PW = srarq_pkg::PAY_W;

  logic [3:0]                  state_r, state_nxt;
  logic [SW-1:0]               seq_r, ack_r;
  logic [PW-1:0]               pay_r;
  logic [SW-1:0]               fe_r, fe_nxt;
  logic [SW-1:0]               ae_r, ae_nxt;
  logic [SW-1:0]               nts_r, nts_nxt;
  logic [SW-1:0]               wt_r, wt_nxt;
  logic [2:0]                  outst_r, outst_nxt;
  logic                        nak_ok_r, nak_ok_nxt;
  logic [srarq_pkg::WINDOW-1:0] arrived_r, arrived_nxt;
  logic [PW-1:0]               rx_store_r [srarq_pkg::WINDOW];
  logic [PW-1:0]               tx_store_r [srarq_pkg::WINDOW];
  logic                        pend_valid_r, pend_valid_nxt;
  srarq_pkg::res_t             pend_r, pend_nxt;

  logic                        new_emit;
  srarq_pkg::res_t             new_res;
  logic                        can_emit;
  logic                        tx_we, rx_we;
  logic [SW-1:0]               cmp_a, cmp_b, cmp_c;
  logic                        cmp_hit;
  logic [SW-1:0]               ack_field;
  logic [SW-1:0]               nak_seq;

  assign in_ready  = (state_r == S_IDLE);
  assign can_emit  = !pend_valid_r || emit_ready;
  assign ack_field = fe_r - SW'(1);
  assign nak_seq   = ack_r + SW'(1);

  // Operand select for the shared window compare
  always_comb begin
    unique case (state_r)
      S_RX_CHK: begin
        cmp_a = fe_r; cmp_b = seq_r; cmp_c = wt_r;
      end
      S_NAK: begin
        cmp_a = ae_r; cmp_b = nak_seq; cmp_c = nts_r;
      end
      S_TMO: begin
        cmp_a = ae_r; cmp_b = seq_r; cmp_c = nts_r;
      end
      default: begin
        cmp_a = ae_r; cmp_b = ack_r; cmp_c = nts_r;
      end
    endcase
  end

  srarq_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .c   (cmp_c),
    .hit (cmp_hit)
  );

  // Step logic
  always_comb begin
    state_nxt      = state_r;
    fe_nxt         = fe_r;
    ae_nxt         = ae_r;
    nts_nxt        = nts_r;
    wt_nxt         = wt_r;
    outst_nxt      = outst_r;
    nak_ok_nxt     = nak_ok_r;
    arrived_nxt    = arrived_r;
    new_emit       = 1'b0;
    new_res        = '0;
    tx_we          = 1'b0;
    rx_we          = 1'b0;
    push           = '0;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (op)
            srarq_pkg::OP_START:   state_nxt = S_START;
            srarq_pkg::OP_SEND:    state_nxt = S_SEND;
            srarq_pkg::OP_DATA_RX: state_nxt = S_RX_NAK;
            srarq_pkg::OP_NAK_RX:  state_nxt = S_NAK;
            srarq_pkg::OP_ACK_RX:  state_nxt = S_REL;
            srarq_pkg::OP_FRM_TMO: state_nxt = S_TMO;
            srarq_pkg::OP_ACK_TMO: state_nxt = S_ACKT;
            default:               state_nxt = S_DONE;
          endcase
        end
      end

      S_START: begin
        fe_nxt      = '0;
        ae_nxt      = '0;
        nts_nxt     = '0;
        wt_nxt      = SW'(srarq_pkg::WINDOW);
        outst_nxt   = '0;
        nak_ok_nxt  = 1'b1;
        arrived_nxt = '0;
        state_nxt   = S_DONE;
      end

      S_SEND: begin
        if (can_emit) begin
          new_emit = 1'b1;
          if (outst_r >= 3'(srarq_pkg::WINDOW)) begin
            new_res = srarq_pkg::mk_res(srarq_pkg::KIND_REFUSED, srarq_pkg::FT_DATA,
                                        '0, '0, '0, srarq_pkg::AT_NONE, outst_r);
          end else begin
            tx_we     = 1'b1;
            outst_nxt = outst_r + 3'd1;
            nts_nxt   = srarq_pkg::seq_inc(nts_r);
            new_res   = srarq_pkg::mk_res(srarq_pkg::KIND_TX, srarq_pkg::FT_DATA, nts_r,
                                          ack_field, pay_r, srarq_pkg::AT_STOP,
                                          outst_r + 3'd1);
          end
          state_nxt = S_DONE;
        end
      end

      S_RX_NAK: begin
        if (can_emit) begin
          new_emit = 1'b1;
          if ((seq_r != fe_r) && nak_ok_r) begin
            nak_ok_nxt = 1'b0;
            new_res    = srarq_pkg::mk_res(srarq_pkg::KIND_TX, srarq_pkg::FT_NAK, '0,
                                           ack_field, '0, srarq_pkg::AT_STOP, outst_r);
          end else begin
            new_res = srarq_pkg::mk_res(srarq_pkg::KIND_NOTHING, srarq_pkg::FT_DATA, '0,
                                        '0, '0, srarq_pkg::AT_RESTART, outst_r);
          end
          state_nxt = S_RX_CHK;
        end
      end

      // Buffer a frame that lands in the receive window
      S_RX_CHK: begin
        if (cmp_hit && !arrived_r[seq_r[WW-1:0]]) begin
          arrived_nxt[seq_r[WW-1:0]] = 1'b1;
          rx_we     = 1'b1;
          state_nxt = S_RX_DLV;
        end else begin
          state_nxt = S_REL;
        end
      end

      // In-order delivery, one frame per step
      S_RX_DLV: begin
        if (arrived_r[fe_r[WW-1:0]]) begin
          if (can_emit) begin
            new_emit                 = 1'b1;
            nak_ok_nxt               = 1'b1;
            arrived_nxt[fe_r[WW-1:0]] = 1'b0;
            fe_nxt                   = srarq_pkg::seq_inc(fe_r);
            wt_nxt                   = srarq_pkg::seq_inc(wt_r);
            new_res = srarq_pkg::mk_res(srarq_pkg::KIND_DELIVER, srarq_pkg::FT_DATA, fe_r,
                                        '0, rx_store_r[fe_r[WW-1:0]],
                                        srarq_pkg::AT_RESTART, outst_r);
          end
        end else begin
          state_nxt = S_REL;
        end
      end

      // Retransmit the frame after the NAK's ack field
      S_NAK: begin
        if (can_emit) begin
          if ((outst_r != '0) && cmp_hit) begin
            new_emit = 1'b1;
            new_res  = srarq_pkg::mk_res(srarq_pkg::KIND_TX, srarq_pkg::FT_DATA, nak_seq,
                                         ack_field, tx_store_r[nak_seq[WW-1:0]],
                                         srarq_pkg::AT_STOP, outst_r);
          end
          state_nxt = S_REL;
        end
      end

      S_TMO: begin
        if (can_emit) begin
          if ((outst_r != '0) && cmp_hit) begin
            new_emit = 1'b1;
            new_res  = srarq_pkg::mk_res(srarq_pkg::KIND_TX, srarq_pkg::FT_DATA, seq_r,
                                         ack_field, tx_store_r[seq_r[WW-1:0]],
                                         srarq_pkg::AT_STOP, outst_r);
          end
          state_nxt = S_DONE;
        end
      end

      S_ACKT: begin
        if (can_emit) begin
          new_emit  = 1'b1;
          new_res   = srarq_pkg::mk_res(srarq_pkg::KIND_TX, srarq_pkg::FT_ACK, '0,
                                        ack_field, '0, srarq_pkg::AT_STOP, outst_r);
          state_nxt = S_DONE;
        end
      end

      // Cumulative release, one slot per step
      S_REL: begin
        if ((outst_r != '0) && cmp_hit) begin
          if (can_emit) begin
            new_emit  = 1'b1;
            outst_nxt = outst_r - 3'd1;
            ae_nxt    = srarq_pkg::seq_inc(ae_r);
            new_res   = srarq_pkg::mk_res(srarq_pkg::KIND_RELEASE, srarq_pkg::FT_DATA, ae_r,
                                          '0, '0, srarq_pkg::AT_NONE, outst_r - 3'd1);
          end
        end else begin
          state_nxt = S_DONE;
        end
      end

      // Flush the held result marked last, or a lone nothing result
      S_DONE: begin
        if (emit_ready) begin
          push.valid = 1'b1;
          if (pend_valid_r) begin
            push.res = pend_r;
          end else begin
            push.res = srarq_pkg::mk_res(srarq_pkg::KIND_NOTHING, srarq_pkg::FT_DATA, '0,
                                         '0, '0, srarq_pkg::AT_NONE, outst_r);
          end
          push.res.last  = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // A new result pushes the held one out, not last
    if (new_emit) begin
      if (pend_valid_r) begin
        push.valid = 1'b1;
        push.res   = pend_r;
      end
      pend_valid_nxt = 1'b1;
      pend_nxt       = new_res;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fe_r         <= '0;
      ae_r         <= '0;
      nts_r        <= '0;
      wt_r         <= SW'(srarq_pkg::WINDOW);
      outst_r      <= '0;
      nak_ok_r     <= 1'b1;
      arrived_r    <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fe_r         <= fe_nxt;
      ae_r         <= ae_nxt;
      nts_r        <= nts_nxt;
      wt_r         <= wt_nxt;
      outst_r      <= outst_nxt;
      nak_ok_r     <= nak_ok_nxt;
      arrived_r    <= arrived_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  // Payload registers and stores
  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    if (in_valid && in_ready) begin
      seq_r <= seq_num;
      ack_r <= ack_num;
      pay_r <= payload;
    end
    if (tx_we) begin
      tx_store_r[nts_r[WW-1:0]] <= pay_r;
    end
    if (rx_we) begin
      rx_store_r[seq_r[WW-1:0]] <= pay_r;
    end
  end

  `SRARQ_ASSERT(a_outst_bound, outst_r <= 3'(srarq_pkg::WINDOW))
  `SRARQ_ASSERT(a_outst_span, outst_r == (nts_r - ae_r))
  `SRARQ_ASSERT(a_push_ready, push.valid |-> emit_ready)
  `SRARQ_NEXT(a_last_idle, push.valid && push.res.last, state_r == S_IDLE)
  `SRARQ_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule

`default_nettype wire

// ----- rtl/selective_repeat_arq_engine_top.sv -----
// Selective-repeat ARQ engine covering both ends of one link (3-bit sequence
// numbers, window of four frames each way).
// Input channel in_*: one link event per request; in_tuser carries the event
// code, in_tdata the sequence number, ack field and payload handle.
// Output channel out_*: the results of an event in order, out_tlast high on
// the final one. Every event yields at least one result.
// Timing: the sequencer takes one step per cycle unless the output stalls it,
// and emits at most one result per step; the steps share a single circular
// window comparator.
// in_tready is high only between events.
// Reset (rst_n low at a clock edge) empties both windows and the output stage;
// the payload stores are not cleared and are read only where written.
// A stall on out_tready holds the output register and, once the one held
// result is also waiting, freezes the sequencer; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none

module selective_repeat_arq_engine_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // seq_num[2:0], ack_num[5:3], payload[21:6], zero pad
  input  wire logic [2:0]  in_tuser,   // op[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // seq_out[2:0], ack_out[5:3], payload_out[21:6],
                                       // ack_timer[23:22], buffered[26:24], zero pad
  output logic [4:0]       out_tuser,  // kind[2:0], frame_type[4:3]
  output logic             out_tlast
);

  logic                    emit_ready;
  srarq_pkg::push_t        push;
  logic                    out_valid_r;
  srarq_pkg::res_t         out_res_r;

  assign emit_ready = !out_valid_r || out_tready;

  srarq_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .op         (in_tuser),
    .seq_num    (in_tdata[2:0]),
    .ack_num    (in_tdata[5:3]),
    .payload    (in_tdata[21:6]),
    .emit_ready (emit_ready),
    .push       (push)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_ready) begin
      out_valid_r <= push.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ready && push.valid) begin
      out_res_r <= push.res;
    end
  end

  // Port packing
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_res_r.last;
  assign out_tuser  = {out_res_r.frame_type, out_res_r.kind};
  assign out_tdata  = {5'd0, out_res_r.buffered, out_res_r.ack_timer,
                       out_res_r.payload_out, out_res_r.ack_out, out_res_r.seq_out};

endmodule

`default_nettype wire

// ----- sim/selective_repeat_arq_engine_top_tb.sv -----
`timescale 1ns / 1ps

module selective_repeat_arq_engine_top_tb;
  import srarq_pkg::*;

  // op 7 has no meaning in the block and must give one empty result
  localparam logic [2:0] OP_UNUSED = 3'd7;

  localparam int RANDOM_EVENTS = 450;
  localparam int QUIET_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 24;

  typedef struct {
    logic [2:0]       op;
    logic [SEQ_W-1:0] seq;
    logic [SEQ_W-1:0] ack;
    logic [PAY_W-1:0] pay;
    int               phase;
  } link_event_t;

  // per-event bookkeeping used when its request is accepted
  typedef struct {
    int nres;
    int phase;
  } event_plan_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  wire         in_tready;
  logic [23:0] in_tdata   = '0;   // seq_num[2:0], ack_num[5:3], payload[21:6], zero pad
  logic [2:0]  in_tuser   = '0;   // op[2:0]
  wire         out_tvalid;
  logic        out_tready = 1'b0;
  wire  [31:0] out_tdata;         // seq_out[2:0], ack_out[5:3], payload_out[21:6],
                                  // ack_timer[23:22], buffered[26:24], zero pad
  wire  [4:0]  out_tuser;         // kind[2:0], frame_type[4:3]
  wire         out_tlast;

  selective_repeat_arq_engine_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #2 clk = ~clk;

  // Link state of the predictor; the sequence space is the full 3-bit range,
  // so plain 3-bit arithmetic gives the modulo-8 wrap.
  logic [SEQ_W-1:0] rx_expected, rx_top, tx_base, tx_next;
  logic [2:0]       tx_count;
  logic             nak_armed;
  logic             rx_marks [WINDOW];
  logic [PAY_W-1:0] rx_slots [WINDOW];
  logic [PAY_W-1:0] tx_slots [WINDOW];

  res_t        event_results[$];
  res_t        planned_results_q[$];
  event_plan_t planned_events_q[$];
  res_t        link_results_q[$];
  link_event_t link_event_q[$];

  int fail_cnt = 0;
  int results_checked = 0;
  int deliveries = 0;
  int refusals = 0;
  int naks_sent = 0;
  int events_sent = 0;

  // circular window test: a <= b < c
  function automatic logic seq_between(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b,
                                       input logic [SEQ_W-1:0] c);
    return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

  function automatic logic [SEQ_W-1:0] ack_field_now();
    return rx_expected - SEQ_W'(1);
  endfunction

  task automatic clear_link();
    rx_expected = '0;
    tx_base     = '0;
    tx_next     = '0;
    rx_top      = SEQ_W'(WINDOW);
    tx_count    = '0;
    nak_armed   = 1'b1;
    foreach (rx_marks[i]) rx_marks[i] = 1'b0;
  endtask

  task automatic post_result(input logic [2:0] kind, input logic [1:0] ft,
                             input logic [SEQ_W-1:0] s, input logic [SEQ_W-1:0] a,
                             input logic [PAY_W-1:0] p, input logic [1:0] at);
    res_t r;
    r.kind        = kind;
    r.frame_type  = ft;
    r.seq_out     = s;
    r.ack_out     = a;
    r.payload_out = p;
    r.ack_timer   = at;
    r.buffered    = tx_count;
    r.last        = 1'b0;
    event_results.insert(event_results.size(), r);
  endtask

  task automatic post_data_frame(input logic [SEQ_W-1:0] s);
    post_result(KIND_TX, FT_DATA, s, ack_field_now(), tx_slots[s[WIN_W-1:0]], AT_STOP);
  endtask

  // cumulative ack: free every slot up to and including a
  task automatic release_through(input logic [SEQ_W-1:0] a);
    logic [SEQ_W-1:0] s;
    while (tx_count != 0 && seq_between(tx_base, a, tx_next)) begin
      s = tx_base;
      tx_count = tx_count - 3'd1;
      tx_base = tx_base + SEQ_W'(1);
      post_result(KIND_RELEASE, FT_DATA, s, '0, '0, AT_NONE);
    end
  endtask

  // Works out the results of one link event and queues them in order
  task automatic arq_advance(input logic [2:0] op, input logic [SEQ_W-1:0] seq,
                             input logic [SEQ_W-1:0] ack, input logic [PAY_W-1:0] pay);
    logic [SEQ_W-1:0] f;
    logic [SEQ_W-1:0] s;
    res_t             r;
    event_plan_t      plan;
    event_results.delete();
    case (op)
      OP_START: clear_link();
      OP_SEND: begin
        if (tx_count >= WINDOW) begin
          post_result(KIND_REFUSED, FT_DATA, '0, '0, '0, AT_NONE);
        end else begin
          tx_count = tx_count + 3'd1;
          tx_slots[tx_next[WIN_W-1:0]] = pay;
          post_data_frame(tx_next);
          tx_next = tx_next + SEQ_W'(1);
        end
      end
      OP_DATA_RX: begin
        if (seq != rx_expected && nak_armed) begin
          nak_armed = 1'b0;
          post_result(KIND_TX, FT_NAK, '0, ack_field_now(), '0, AT_STOP);
        end else begin
          post_result(KIND_NOTHING, FT_DATA, '0, '0, '0, AT_RESTART);
        end
        if (seq_between(rx_expected, seq, rx_top) && !rx_marks[seq[WIN_W-1:0]]) begin
          rx_marks[seq[WIN_W-1:0]] = 1'b1;
          rx_slots[seq[WIN_W-1:0]] = pay;
          // hand up every frame now contiguous with the window base
          while (rx_marks[rx_expected[WIN_W-1:0]]) begin
            f = rx_expected;
            nak_armed = 1'b1;
            rx_marks[f[WIN_W-1:0]] = 1'b0;
            rx_expected = rx_expected + SEQ_W'(1);
            rx_top = rx_top + SEQ_W'(1);
            post_result(KIND_DELIVER, FT_DATA, f, '0, rx_slots[f[WIN_W-1:0]], AT_RESTART);
          end
        end
        release_through(ack);
      end
      OP_NAK_RX: begin
        s = ack + SEQ_W'(1);
        if (tx_count != 0 && seq_between(tx_base, s, tx_next)) post_data_frame(s);
        release_through(ack);
      end
      OP_ACK_RX: release_through(ack);
      OP_FRM_TMO: begin
        // stale timers fall outside the send window and are dropped
        if (tx_count != 0 && seq_between(tx_base, seq, tx_next)) post_data_frame(seq);
      end
      OP_ACK_TMO: post_result(KIND_TX, FT_ACK, '0, ack_field_now(), '0, AT_STOP);
      default: ;
    endcase
    if (event_results.size() == 0) post_result(KIND_NOTHING, FT_DATA, '0, '0, '0, AT_NONE);
    foreach (event_results[i]) begin
      r = event_results[i];
      r.last = (i == event_results.size() - 1);
      planned_results_q.insert(planned_results_q.size(), r);
    end
    plan.nres = event_results.size();
    plan.phase = 0;
    planned_events_q.insert(planned_events_q.size(), plan);
  endtask

  task automatic queue_event(input logic [2:0] op, input logic [SEQ_W-1:0] seq,
                             input logic [SEQ_W-1:0] ack, input logic [PAY_W-1:0] pay,
                             input int phase);
    link_event_t ev;
    arq_advance(op, seq, ack, pay);
    planned_events_q[planned_events_q.size() - 1].phase = phase;
    ev.op = op;
    ev.seq = seq;
    ev.ack = ack;
    ev.pay = pay;
    ev.phase = phase;
    link_event_q.insert(link_event_q.size(), ev);
  endtask

  // Mostly well-formed peer traffic aimed at the current windows, some noise
  task automatic add_random_event(input int phase);
    int               pick;
    int               v;
    logic [2:0]       op;
    logic [SEQ_W-1:0] seq;
    logic [SEQ_W-1:0] ack;
    logic [PAY_W-1:0] pay;
    seq = SEQ_W'($urandom);
    ack = SEQ_W'($urandom);
    pay = PAY_W'($urandom);
    if ($urandom_range(0, 99) < 85) ack = tx_base - SEQ_W'(1) + SEQ_W'($urandom_range(0, tx_count));
    if ($urandom_range(0, 99) < 12) begin
      op = 3'($urandom_range(0, 7));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 24) op = OP_SEND;
      else if (pick < 54) op = OP_DATA_RX;
      else if (pick < 62) op = OP_NAK_RX;
      else if (pick < 74) op = OP_ACK_RX;
      else if (pick < 84) op = OP_FRM_TMO;
      else if (pick < 94) op = OP_ACK_TMO;
      else if (pick < 97) op = OP_UNUSED;
      else op = OP_START;
      if (op == OP_DATA_RX) begin
        v = $urandom_range(0, 9);
        if (v < 3) seq = rx_expected;
        else if (v < 8) seq = rx_expected + SEQ_W'($urandom_range(1, WINDOW - 1));
      end
      if (op == OP_FRM_TMO && tx_count != 0 && $urandom_range(0, 99) < 80)
        seq = tx_base + SEQ_W'($urandom_range(0, int'(tx_count) - 1));
    end
    queue_event(op, seq, ack, pay, phase);
  endtask

  // phase 0: free flow, 1: sender idles, 2: receiver stalls, 3: both, lightly
  function automatic logic hold_back(input int phase, input logic sender_side);
    int pct;
    case (phase)
      1: pct = sender_side ? 72 : 0;
      2: pct = sender_side ? 0 : 72;
      3: pct = 14;
      default: pct = 0;
    endcase
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic check_field(input string name, input logic [PAY_W-1:0] want_v,
                             input logic [PAY_W-1:0] got_v);
    if (want_v !== got_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
      fail_cnt++;
    end
  endtask

  // Driver: present the oldest pending event, idle at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        void'(link_event_q.pop_front());
        events_sent++;
      end
      if (link_event_q.size() != 0 && !hold_back(link_event_q[0].phase, 1'b1)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {2'b00, link_event_q[0].pay, link_event_q[0].ack, link_event_q[0].seq};
        in_tuser  <= link_event_q[0].op;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: arm expectations on each accepted request, check each result
  event_plan_t arm_plan;
  int          out_phase = 0;
  res_t        got_res;
  res_t        want_res;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        arm_plan = planned_events_q.pop_front();
        out_phase = arm_plan.phase;
        repeat (arm_plan.nres)
          link_results_q.insert(link_results_q.size(), planned_results_q.pop_front());
      end
      if (out_tvalid && out_tready) begin
        got_res.kind        = out_tuser[2:0];
        got_res.frame_type  = out_tuser[4:3];
        got_res.seq_out     = out_tdata[2:0];
        got_res.ack_out     = out_tdata[5:3];
        got_res.payload_out = out_tdata[21:6];
        got_res.ack_timer   = out_tdata[23:22];
        got_res.buffered    = out_tdata[26:24];
        got_res.last        = out_tlast;
        results_checked++;
        if (got_res.kind == KIND_DELIVER) deliveries++;
        if (got_res.kind == KIND_REFUSED) refusals++;
        if (got_res.kind == KIND_TX && got_res.frame_type == FT_NAK) naks_sent++;
        if (link_results_q.size() == 0) begin
          $error("result with no expectation: kind %0d seq %0d", got_res.kind, got_res.seq_out);
          fail_cnt++;
        end else begin
          want_res = link_results_q.pop_front();
          check_field("kind", want_res.kind, got_res.kind);
          check_field("frame_type", want_res.frame_type, got_res.frame_type);
          check_field("seq_out", want_res.seq_out, got_res.seq_out);
          check_field("ack_out", want_res.ack_out, got_res.ack_out);
          check_field("payload_out", want_res.payload_out, got_res.payload_out);
          check_field("ack_timer", want_res.ack_timer, got_res.ack_timer);
          check_field("buffered", want_res.buffered, got_res.buffered);
          check_field("last", want_res.last, got_res.last);
        end
      end
      out_tready <= !hold_back(out_phase, 1'b0);
    end
  end

  // Watchdog: no request accepted on the input side for too long
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    clear_link();

    // Directed: fill the send window, then the refusal on a full window
    queue_event(OP_START, 3'd0, 3'd0, 16'h0000, 0);
    queue_event(OP_SEND, 3'd0, 3'd0, 16'h0000, 0);
    queue_event(OP_SEND, 3'd7, 3'd7, 16'hFFFF, 0);
    queue_event(OP_SEND, 3'd0, 3'd0, 16'h1234, 0);
    queue_event(OP_SEND, 3'd0, 3'd0, 16'h8001, 0);
    queue_event(OP_SEND, 3'd0, 3'd0, 16'h4321, 0);
    // timeout inside the window retransmits, a stale one is ignored
    queue_event(OP_FRM_TMO, 3'd1, 3'd0, 16'h0000, 0);
    queue_event(OP_FRM_TMO, 3'd5, 3'd0, 16'h0000, 0);
    // NAK for the frame after ack 7 resends frame 0, releases nothing
    queue_event(OP_NAK_RX, 3'd0, 3'd7, 16'h0000, 0);
    queue_event(OP_ACK_RX, 3'd0, 3'd7, 16'h0000, 0);
    // out-of-order arrivals, then the gap filler: four deliveries and four releases
    queue_event(OP_DATA_RX, 3'd1, 3'd7, 16'hFFFF, 0);
    queue_event(OP_DATA_RX, 3'd3, 3'd7, 16'h0000, 0);
    queue_event(OP_DATA_RX, 3'd2, 3'd7, 16'hAAAA, 0);
    queue_event(OP_DATA_RX, 3'd0, 3'd3, 16'h5555, 0);
    // repeated frame outside the receive window
    queue_event(OP_DATA_RX, 3'd1, 3'd3, 16'h0F0F, 0);
    queue_event(OP_ACK_TMO, 3'd0, 3'd0, 16'h0000, 0);
    queue_event(OP_UNUSED, 3'd7, 3'd7, 16'hFFFF, 0);
    // empty events with nothing outstanding
    queue_event(OP_FRM_TMO, 3'd0, 3'd0, 16'h0000, 0);
    queue_event(OP_ACK_RX, 3'd0, 3'd4, 16'h0000, 0);
    queue_event(OP_DATA_RX, 3'd7, 3'd0, 16'hC3C3, 0);
    // start drops the buffered frame and both windows
    queue_event(OP_START, 3'd7, 3'd7, 16'hFFFF, 0);
    queue_event(OP_SEND, 3'd0, 3'd0, 16'h7FFF, 0);
    queue_event(OP_DATA_RX, 3'd0, 3'd0, 16'hFFFF, 0);
    queue_event(OP_ACK_TMO, 3'd0, 3'd0, 16'h0000, 0);

    for (int phase = 0; phase < 4; phase++) begin
      repeat (RANDOM_EVENTS / 4) add_random_event(phase);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (link_event_q.size() != 0 || planned_events_q.size() != 0 ||
           link_results_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d link events and %0d results: %0d deliveries, %0d NAKs, %0d refusals",
             events_sent, results_checked, deliveries, naks_sent, refusals);
    $display("Flow phases: free running, sender idling, receiver stalling, both");
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
